FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CDST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CDST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/cdst_pkg.sv
// Shared types, codes and the CRC-8 byte function of the device status table.
// No dependencies.
`default_nettype none

package cdst_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [7:0] MSG_ON  = 8'hFF;
  localparam logic [7:0] MSG_OFF = 8'h00;
  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [2:0] ST_NOTINUSE     = 3'd0;
  localparam logic [2:0] ST_ON           = 3'd1;
  localparam logic [2:0] ST_ON_FIRST     = 3'd2;
  localparam logic [2:0] ST_OFF          = 3'd3;
  localparam logic [2:0] ST_GARBLE       = 3'd4;
  localparam logic [2:0] ST_PRESUMED_OFF = 3'd5;

  localparam logic [2:0] OUT_CRC_REJECTED = 3'd0;
  localparam logic [2:0] OUT_UPDATED      = 3'd1;
  localparam logic [2:0] OUT_ADDED        = 3'd2;
  localparam logic [2:0] OUT_NOT_STORED   = 3'd3;
  localparam logic [2:0] OUT_NO_SPACE     = 3'd4;

  localparam int CLASSES = 4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic load;
    logic crc_step;
    logic scan_step;
    logic commit;
  } cdst_cmd_t;

  typedef struct packed {
    logic crc_last;
    logic crc_ok;
    logic scan_last;
    logic out_free;
  } cdst_status_t;

  // Status codes claimed by a new id, in order of preference.
  function automatic logic [2:0] fill_class(input int k);
    logic [2:0] c;
    unique case (k)
      0:       c = ST_NOTINUSE;
      1:       c = ST_GARBLE;
      2:       c = ST_OFF;
      default: c = ST_PRESUMED_OFF;
    endcase
    return c;
  endfunction

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cdst_ctrl.sv
// Controller state machine of the device status table.
// Depends on cdst_pkg for the command and status structs.
`default_nettype none

module cdst_ctrl
  import cdst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire cdst_status_t sts,
  output cdst_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CRC    = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CRC;
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.crc_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.crc_ok) begin
          state_next = S_COMMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_next = S_COMMIT;
        end
      end
      default: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdst_datapath.sv
// Datapath of the device status table: CRC, table stores, scan and result register.
// Depends on cdst_pkg; driven by cdst_ctrl through command and status structs.
`default_nettype none

module cdst_datapath
  import cdst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cdst_cmd_t    cmd,
  output cdst_status_t      sts,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  input  wire logic [15:0]  device_id,
  input  wire logic [7:0]   message,
  input  wire logic [7:0]   check_byte,
  input  wire logic [31:0]  current_time,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        outcome,
  output logic [4:0]        entry_index,
  output logic [15:0]       devices_on
);

  logic [15:0] id_r;
  logic [7:0]  msg_r;
  logic [7:0]  chk_r;
  logic [31:0] time_r;
  logic [7:0]  crc;
  logic [1:0]  byte_cnt;
  idx_t        scan_idx;
  logic        hit;
  idx_t        hit_idx;
  logic [CLASSES-1:0] cls_found;
  idx_t        cls_idx [CLASSES];
  logic        log_all_mode;
  logic [15:0] on_counter;

  logic [ENTRIES-1:0] ent_valid;
  logic [15:0] id_store        [ENTRIES];
  logic [2:0]  status_store    [ENTRIES];
  logic [31:0] last_seen_store [ENTRIES];

  logic [15:0] rd_id;
  logic [2:0]  rd_st;
  logic [7:0]  crc_byte;
  logic        crc_ok;

  logic        sel_found;
  idx_t        sel_idx;
  logic        wr_entry;
  logic        wr_time;
  logic [2:0]  wr_status;
  logic [2:0]  res_outcome;
  logic [15:0] on_counter_next;

  // Entries never written read as their reset value.
  assign rd_id = ent_valid[scan_idx] ? id_store[scan_idx] : 16'd0;
  assign rd_st = ent_valid[scan_idx] ? status_store[scan_idx] : ST_NOTINUSE;

  always_comb begin
    unique case (byte_cnt)
      2'd0:    crc_byte = id_r[15:8];
      2'd1:    crc_byte = id_r[7:0];
      default: crc_byte = msg_r;
    endcase
  end

  assign crc_ok = (crc == chk_r);

  assign sts.crc_last  = (byte_cnt == 2'd2);
  assign sts.crc_ok    = crc_ok;
  assign sts.scan_last = (scan_idx == idx_t'(ENTRIES - 1));
  assign sts.out_free  = !out_valid || out_ready;

  // Free entry choice: lowest index of the most preferred class seen.
  always_comb begin
    sel_found = 1'b0;
    sel_idx = '0;
    for (int k = CLASSES - 1; k >= 0; k--) begin
      if (cls_found[k]) begin
        sel_found = 1'b1;
        sel_idx = cls_idx[k];
      end
    end
  end

  always_comb begin
    wr_entry = 1'b0;
    wr_time = 1'b0;
    wr_status = ST_ON;
    res_outcome = OUT_NO_SPACE;
    on_counter_next = on_counter;
    if (!crc_ok) begin
      res_outcome = OUT_CRC_REJECTED;
    end else if (hit) begin
      wr_time = 1'b1;
      res_outcome = OUT_UPDATED;
      if (msg_r == MSG_ON) begin
        wr_entry = 1'b1;
        wr_status = ST_ON;
      end else if (msg_r == MSG_OFF) begin
        wr_entry = 1'b1;
        wr_status = ST_OFF;
      end
    end else if (sel_found) begin
      wr_time = 1'b1;
      if (msg_r == MSG_ON) begin
        wr_entry = 1'b1;
        wr_status = ST_ON_FIRST;
        res_outcome = OUT_ADDED;
        if (on_counter != 16'hFFFF) on_counter_next = on_counter + 16'd1;
      end else if (log_all_mode) begin
        wr_entry = 1'b1;
        wr_status = (msg_r == MSG_OFF) ? ST_OFF : ST_GARBLE;
        res_outcome = OUT_ADDED;
      end else begin
        res_outcome = OUT_NOT_STORED;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      log_all_mode <= 1'b0;
      on_counter <= '0;
      ent_valid <= '0;
      out_valid <= 1'b0;
      hit <= 1'b0;
      cls_found <= '0;
      byte_cnt <= '0;
      scan_idx <= '0;
    end else begin
      if (cfg_we) log_all_mode <= cfg_wdata;
      if (cmd.load) begin
        hit <= 1'b0;
        cls_found <= '0;
        byte_cnt <= '0;
        scan_idx <= '0;
      end
      if (cmd.crc_step) byte_cnt <= byte_cnt + 2'd1;
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + idx_t'(1);
        if (!hit && rd_id == id_r) hit <= 1'b1;
        for (int k = 0; k < CLASSES; k++) begin
          if (!cls_found[k] && rd_st == fill_class(k)) cls_found[k] <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        on_counter <= on_counter_next;
        if (wr_entry) ent_valid[hit ? hit_idx : sel_idx] <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers and table contents.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r <= device_id;
      msg_r <= message;
      chk_r <= check_byte;
      time_r <= current_time;
      crc <= 8'd0;
    end
    if (cmd.crc_step) crc <= crc8_byte(crc, crc_byte);
    if (cmd.scan_step) begin
      if (!hit && rd_id == id_r) hit_idx <= scan_idx;
      for (int k = 0; k < CLASSES; k++) begin
        if (!cls_found[k] && rd_st == fill_class(k)) cls_idx[k] <= scan_idx;
      end
    end
    if (cmd.commit) begin
      outcome <= res_outcome;
      devices_on <= on_counter_next;
      entry_index <= (crc_ok && (hit || sel_found)) ? 5'(hit ? hit_idx : sel_idx) : 5'd0;
      if (wr_entry) begin
        id_store[hit ? hit_idx : sel_idx] <= id_r;
        status_store[hit ? hit_idx : sel_idx] <= wr_status;
      end
      if (wr_time) last_seen_store[hit ? hit_idx : sel_idx] <= time_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/crc_checked_device_status_table.sv
// Top level of the CRC-checked device status table.
// Depends on cdst_pkg, cdst_ctrl and cdst_datapath.
//
//   Channel  Handshake            Payload
//   input    in_valid/in_ready    device_id, message, check_byte, current_time
//   output   out_valid/out_ready  outcome, entry_index, devices_on
//   config   cfg_we               cfg_wdata (log_all_mode)
//
// When the CRC matches, an item goes through the byte-wise CRC over three bytes and
// then the table scan, which reads one entry per cycle, before its result is ready;
// when the CRC does not match, the scan is skipped.
// Reset clears the table at once through per-entry valid bits; no clearing pass.
// A result waits in the output register while the next item is taken and worked on;
// the block stalls only at its final step if that register is still full.
`default_nettype none

module crc_checked_device_status_table
  import cdst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] device_id,
  input  wire logic [7:0]  message,
  input  wire logic [7:0]  check_byte,
  input  wire logic [31:0] current_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       outcome,
  output logic [4:0]       entry_index,
  output logic [15:0]      devices_on
);

  // The controller sequences load, CRC, scan and commit; the datapath does the work
  // and reports when each phase has ended.
  cdst_cmd_t    cmd;
  cdst_status_t sts;

  cdst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table, the on-counter, the mode bit and the result register.
  cdst_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .device_id    (device_id),
    .message      (message),
    .check_byte   (check_byte),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .outcome      (outcome),
    .entry_index  (entry_index),
    .devices_on   (devices_on)
  );

endmodule

`default_nettype wire

FILE: rtl/core/cdst_checker.sv
// Port-level checker for the device status table, bound to the top level.
// Depends on cdst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cdst_checker
  import cdst_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic        cfg_wdata,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [15:0] device_id,
  input wire logic [7:0]  message,
  input wire logic [7:0]  check_byte,
  input wire logic [31:0] current_time,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  outcome,
  input wire logic [4:0]  entry_index,
  input wire logic [15:0] devices_on
);

  `CDST_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")
  `CDST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `CDST_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second item taken")
  `CDST_ASSERT(a_no_index, out_valid && (outcome == OUT_CRC_REJECTED || outcome == OUT_NO_SPACE) |-> entry_index == 5'd0, "index given without entry")

endmodule

bind crc_checked_device_status_table cdst_checker u_cdst_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the CRC-checked device status table.
// Depends on cdst_pkg and the crc_checked_device_status_table RTL.
`timescale 1ns / 1ps

module tb_top;
  import cdst_pkg::*;

  localparam int TIMEOUT_CYCLES = 20000;

  // Per-report result as predicted by the table model below.
  typedef struct packed {
    logic [2:0]  outcome;
    logic [4:0]  entry_index;
    logic [15:0] devices_on;
  } report_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] device_id = '0;
  logic [7:0]  message = '0;
  logic [7:0]  check_byte = '0;
  logic [31:0] current_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  outcome;
  logic [4:0]  entry_index;
  logic [15:0] devices_on;

  crc_checked_device_status_table uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .device_id(device_id),
    .message(message), .check_byte(check_byte), .current_time(current_time),
    .out_valid(out_valid), .out_ready(out_ready), .outcome(outcome),
    .entry_index(entry_index), .devices_on(devices_on)
  );

  always #10 clk = ~clk;

  // Shadow copy of the device table and its settings.
  logic [15:0] shadow_ids [ENTRIES];
  logic [2:0]  shadow_status [ENTRIES];
  logic [31:0] shadow_seen [ENTRIES];
  logic [15:0] shadow_on_count;
  logic        shadow_log_all;

  report_result_t pending_results[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  logic [31:0] clock_stamp = 0;

  // Running CRC-8 (poly 0x07, MSB first) over the id bytes and message.
  function automatic logic [7:0] report_crc(logic [15:0] id, logic [7:0] msg);
    logic [23:0] bits;
    logic [7:0]  c;
    bits = {id, msg};
    c = 8'h00;
    for (int i = 23; i >= 0; i--) begin
      if (c[7] ^ bits[i]) c = {c[6:0], 1'b0} ^ 8'h07;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Applies one report to the shadow table and returns the expected result.
  function automatic report_result_t apply_report(logic [15:0] id, logic [7:0] msg,
                                                  logic [7:0] chk, logic [31:0] now);
    report_result_t r;
    logic [2:0] wanted;
    bit hit;
    hit = 0;
    r.outcome = OUT_NO_SPACE;
    r.entry_index = '0;
    if (report_crc(id, msg) != chk) begin
      r.outcome = OUT_CRC_REJECTED;
    end else begin
      // Id match ignores status, so a cleared entry still matches id zero.
      for (int i = 0; i < ENTRIES && !hit; i++) begin
        if (shadow_ids[i] == id) begin
          hit = 1;
          r.entry_index = i[4:0];
          shadow_seen[i] = now;
          if (msg == MSG_ON) shadow_status[i] = ST_ON;
          else if (msg == MSG_OFF) shadow_status[i] = ST_OFF;
          r.outcome = OUT_UPDATED;
        end
      end
      // Miss: claim an entry by preference of its current status.
      for (int p = 0; p < 4 && !hit; p++) begin
        case (p)
          0: wanted = ST_NOTINUSE;
          1: wanted = ST_GARBLE;
          2: wanted = ST_OFF;
          default: wanted = ST_PRESUMED_OFF;
        endcase
        for (int i = 0; i < ENTRIES && !hit; i++) begin
          if (shadow_status[i] == wanted) begin
            hit = 1;
            r.entry_index = i[4:0];
            shadow_seen[i] = now;
            if (msg == MSG_ON) begin
              shadow_status[i] = ST_ON_FIRST;
              shadow_ids[i] = id;
              if (shadow_on_count != 16'hFFFF) shadow_on_count++;
              r.outcome = OUT_ADDED;
            end else if (shadow_log_all) begin
              shadow_status[i] = (msg == MSG_OFF) ? ST_OFF : ST_GARBLE;
              shadow_ids[i] = id;
              r.outcome = OUT_ADDED;
            end else begin
              r.outcome = OUT_NOT_STORED;
            end
          end
        end
      end
    end
    r.devices_on = shadow_on_count;
    return r;
  endfunction

  // Sends one report; inputs move on the falling edge, acceptance is seen at
  // the rising edge. Each report starts at a later falling edge than the one
  // that dropped the previous valid.
  task automatic send_report(logic [15:0] id, logic [7:0] msg, logic [7:0] chk,
                             logic [31:0] now);
    do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    in_valid <= 1'b1;
    device_id <= id;
    message <= msg;
    check_byte <= chk;
    current_time <= now;
    pending_results.push_back(apply_report(id, msg, chk, now));
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // A well-formed report carries its own correct check byte.
  task automatic send_good(logic [15:0] id, logic [7:0] msg);
    clock_stamp = clock_stamp + $urandom_range(1, 1000);
    send_report(id, msg, report_crc(id, msg), clock_stamp);
  endtask

  // The register may only change once the table has gone quiet.
  task automatic set_log_all(logic mode);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_log_all = mode;
  endtask

  // Receiver side: random stall, compare each item with the oldest prediction.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    report_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: outcome %0d index %0d on %0d",
                   outcome, entry_index, devices_on);
      end else begin
        exp_r = pending_results.pop_front();
        if (outcome !== exp_r.outcome || entry_index !== exp_r.entry_index ||
            devices_on !== exp_r.devices_on) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp outcome %0d index %0d on %0d, got %0d %0d %0d",
                     exp_r.outcome, exp_r.entry_index, exp_r.devices_on,
                     outcome, entry_index, devices_on);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > TIMEOUT_CYCLES) begin
      $display("crc_checked_device_status_table verification failed");
      $finish;
    end
  end

  // Directed cases: id zero matching a cleared entry, field extremes, bad CRC.
  task automatic test_directed();
    send_good(16'h0000, 8'h55);
    send_good(16'hFFFF, 8'h00);
    send_good(16'hFFFF, MSG_ON);
    send_good(16'hFFFF, MSG_ON);
    send_good(16'hFFFF, MSG_OFF);
    send_good(16'hFFFF, 8'hA5);
    send_report(16'h1234, MSG_ON, ~report_crc(16'h1234, MSG_ON), 32'hFFFFFFFF);
    send_report(16'hAAAA, 8'h5A, 8'h00, 32'h0);
    send_report(16'h1234, MSG_ON, report_crc(16'h1234, MSG_ON), 32'hFFFFFFFF);
    send_good(16'h0000, MSG_ON);
    send_good(16'h5555, 8'h01);
  endtask

  // Fill the table so that every preference pass and the full case are hit.
  task automatic test_table_fill(logic mode);
    set_log_all(mode);
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(2))
        0: send_good(16'(16'h8000 + i), MSG_ON);
        1: send_good(16'(16'h8000 + i), MSG_OFF);
        default: send_good(16'(16'h8000 + i), 8'h80 | i[7:0]);
      endcase
    end
    for (int i = 0; i < 10; i++) send_good(16'($urandom_range(16'hFFFF)), MSG_ON);
  endtask

  // Mostly valid reports from a small id pool, some corrupted.
  task automatic test_random(int count);
    logic [15:0] id;
    logic [7:0]  msg;
    for (int n = 0; n < count; n++) begin
      id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(47));
      case ($urandom_range(3))
        0: msg = MSG_ON;
        1: msg = MSG_OFF;
        default: msg = 8'($urandom);
      endcase
      clock_stamp = $urandom;
      if ($urandom_range(9) == 0) send_report(id, msg, 8'($urandom), clock_stamp);
      else send_report(id, msg, report_crc(id, msg), clock_stamp);
      if (n % 200 == 199) set_log_all(1'($urandom_range(1)));
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_ids[i] = '0;
      shadow_status[i] = ST_NOTINUSE;
      shadow_seen[i] = '0;
    end
    shadow_on_count = '0;
    shadow_log_all = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    send_gap_pct = 8;
    recv_stall_pct = 53;
    test_directed();
    test_table_fill(1'b1);
    test_random(450);
    send_gap_pct = 53;
    recv_stall_pct = 8;
    test_table_fill(1'b0);
    test_random(450);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_log_all(1'b1);
    test_random(450);
    set_log_all(1'b0);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("crc_checked_device_status_table verification clean");
    end else begin
      $display("crc_checked_device_status_table verification failed");
    end
    $finish;
  end

endmodule
